/* rtl/sha1_pkg.sv */
// Shared types and constants for the SHA-1 hash engine.
package sha1_pkg;

    typedef enum logic {
        CMD_BYTE   = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t        kind;
        logic [63:0] data;
    } q_entry_t;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

/* rtl/sha1_hash_engine.sv */
// SHA-1 hash engine top level: front end, command queue and compression back end.
// Each full 64-byte block runs 80 rounds on the single round unit, then one
// chaining update; meanwhile new commands wait in the queue.
// Finish: padding and length bytes fill one or two blocks, then five words.
// Reset: asynchronous active-low; chaining words and byte count return to initial values.
module sha1_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        action,
    input  logic [7:0]  data_byte,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last
);

    // queue handshake between front end and back end
    logic               q_ready;
    logic               q_push;
    sha1_pkg::q_entry_t q_push_entry;
    logic               q_pop;
    logic               q_valid;
    sha1_pkg::q_entry_t q_pop_entry;

    // Accept transactions and turn them into byte or finish commands;
    // finish carries the message length in bits.
    sha1_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .action    (action),
        .data_byte (data_byte),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_entry   (q_push_entry)
    );

    // Hold commands while the back end runs rounds; the front accepts until it fills.
    sha1_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_pop_entry)
    );

    // Assemble blocks, pad, compress and drive the registered digest output.
    sha1_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_entry     (q_pop_entry),
        .q_pop       (q_pop),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last        (last)
    );

endmodule

/* rtl/sha1_front.sv */
// Front end: accept transactions, count message bytes, classify into queue commands.
module sha1_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic               action,
    input  logic [7:0]         data_byte,
    input  logic               q_ready,
    output logic               q_push,
    output sha1_pkg::q_entry_t q_entry
);

    logic [60:0] count_reg;
    logic [60:0] count_next;

    assign req_ready = q_ready;
    assign q_push    = req_valid && q_ready;

    always_comb
    begin
        count_next = count_reg;
        if (action == sha1_pkg::CMD_FINISH)
        begin
            q_entry.kind = sha1_pkg::CMD_FINISH;
            q_entry.data = {count_reg, 3'b000};
            count_next   = '0;
        end
        else
        begin
            q_entry.kind = sha1_pkg::CMD_BYTE;
            q_entry.data = {56'd0, data_byte};
            count_next   = count_reg + 61'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (q_push)
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/sha1_fifo.sv */
// Short command queue between front end and compression back end.
module sha1_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sha1_pkg::q_entry_t push_entry,
    output logic               push_ready,
    input  logic               pop,
    output logic               pop_valid,
    output sha1_pkg::q_entry_t pop_entry
);

    sha1_pkg::q_entry_t mem [sha1_pkg::Q_DEPTH];

    logic [sha1_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [sha1_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [sha1_pkg::Q_PTR_W:0]   fill_reg;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = (fill_reg != sha1_pkg::Q_PTR_W'(0) + (sha1_pkg::Q_PTR_W+1)'(sha1_pkg::Q_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/sha1_back.sv */
// Back end: block assembly, padding, 80-round compression and digest output.
module sha1_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  sha1_pkg::q_entry_t q_entry,
    output logic               q_pop,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [31:0]        digest_word,
    output logic [2:0]         word_index,
    output logic               last
);

    typedef enum logic [5:0] {
        S_ACCEPT = 6'b000001,
        S_PAD    = 6'b000010,
        S_LEN    = 6'b000100,
        S_ROUND  = 6'b001000,
        S_UPD    = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [5:0]        pos_reg, pos_next;
    logic [23:0]       acc_reg, acc_next;
    logic [63:0]       len_reg, len_next;
    logic              first_reg, first_next;
    logic [6:0]        rnd_reg, rnd_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [4:0][31:0]  h_reg;
    logic [31:0]       a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]       sched [16];
    logic              out_valid_reg;
    logic [31:0]       out_word_reg;
    logic [2:0]        out_idx_reg;

    logic              ins_valid;
    logic [7:0]        ins_byte;
    logic              out_load;
    logic              block_full;
    logic [31:0]       f_val;
    logic [31:0]       k_val;
    logic [31:0]       t_val;
    logic [31:0]       w_new;

    assign block_full = ins_valid && (pos_reg == 6'd63);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        len_next   = len_reg;
        first_next = first_reg;
        rnd_next   = rnd_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        ins_valid  = 1'b0;
        ins_byte   = 8'd0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_ACCEPT:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_entry.kind == sha1_pkg::CMD_BYTE)
                    begin
                        ins_valid = 1'b1;
                        ins_byte  = q_entry.data[7:0];
                    end
                    else
                    begin
                        len_next   = q_entry.data;
                        first_next = 1'b1;
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                ins_valid  = 1'b1;
                ins_byte   = first_reg ? sha1_pkg::PAD_BYTE : 8'd0;
                first_next = 1'b0;
                if (pos_reg == 6'd55)
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                ins_valid = 1'b1;
                ins_byte  = len_reg[63:56];
                len_next  = {len_reg[55:0], 8'd0};
            end
            S_ROUND:
            begin
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'd79)
                begin
                    rnd_next   = '0;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                state_next = ret_reg;
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_load = 1'b1;
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd4)
                    begin
                        cnt_next   = '0;
                        state_next = S_ACCEPT;
                    end
                end
            end
            default:
            begin
                state_next = S_ACCEPT;
            end
        endcase

        if (ins_valid)
        begin
            pos_next = pos_reg + 6'd1;
            acc_next = {acc_reg[15:0], ins_byte};
            if (block_full)
            begin
                // resume where the byte came from; length bytes lead to output
                ret_next   = (state_reg == S_LEN) ? S_OUT : state_reg;
                state_next = S_ROUND;
            end
        end
    end

    // round function
    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1_pkg::K_0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K_1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1_pkg::K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K_3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + sched[0];
    assign w_new = {sched[13][30:0] ^ sched[8][30:0] ^ sched[2][30:0] ^ sched[0][30:0],
                    sched[13][31] ^ sched[8][31] ^ sched[2][31] ^ sched[0][31]};

    // message schedule window, oldest word at index 0
    always_ff @(posedge clk)
    begin
        if ((ins_valid && (pos_reg[1:0] == 2'd3)) || (state_reg == S_ROUND))
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched[i] <= sched[i+1];
            end
            sched[15] <= (state_reg == S_ROUND) ? w_new : {acc_reg, ins_byte};
        end
    end

    always_ff @(posedge clk)
    begin
        if (block_full)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (state_reg == S_ROUND)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        len_reg <= len_next;
        if (out_load)
        begin
            out_word_reg <= h_reg[cnt_reg];
            out_idx_reg  <= cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACCEPT;
            ret_reg       <= S_ACCEPT;
            pos_reg       <= '0;
            first_reg     <= 1'b0;
            rnd_reg       <= '0;
            cnt_reg       <= '0;
            h_reg         <= sha1_pkg::H_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            pos_reg   <= pos_next;
            first_reg <= first_next;
            rnd_reg   <= rnd_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_UPD)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            else if (out_load && (cnt_reg == 3'd4))
            begin
                h_reg <= sha1_pkg::H_INIT;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign digest_word = out_word_reg;
    assign word_index  = out_idx_reg;
    assign last        = (out_idx_reg == 3'd4);

    a_round_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (pos_reg == 6'd0))
        else $error("compression started off a block boundary");

    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (rnd_reg < 7'd80))
        else $error("round counter out of range");

    a_len_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEN) |-> (pos_reg[5:3] == 3'b111))
        else $error("length bytes outside the block tail");

    a_chain_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (cnt_reg == 3'd4)) |=>
        ((h_reg == sha1_pkg::H_INIT) && (state_reg == S_ACCEPT) && last))
        else $error("chain not restored after digest");

endmodule

/* dv/sha1_hash_engine_tb.sv */
// Self-checking testbench for the SHA-1 hash engine: directed table, random messages, checker.
module sha1_hash_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One digest word as the engine returns it.
    typedef struct packed {
        logic [31:0] word_val;
        logic [2:0]  word_idx;
        logic        is_last;
    } digest_word_t;

    // One row of the directed table; a known digest is typed in only where it is
    // a textbook value, otherwise the software hash supplies it.
    typedef struct packed {
        sha1_pkg::cmd_t kind;
        logic [7:0]     octet;
        logic           known;
        logic [159:0]   digest;
    } stim_row_t;

    localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] ABC_DIGEST   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;
    localparam int N_DIRECTED   = 14;
    localparam int PHASE_ITEMS  = 86;
    localparam int SETTLE_TICKS = 300;

    logic           clk;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    sha1_pkg::cmd_t action    = sha1_pkg::CMD_BYTE;
    logic [7:0]     data_byte = 8'h00;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    logic [31:0]    digest_word;
    logic [2:0]     word_index;
    logic           last;

    sha1_hash_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .action      (action),
        .data_byte   (data_byte),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last        (last)
    );

    // Software copy of the hash state: chaining words, block buffer, byte count.
    logic [31:0] chain_h [5];
    logic [7:0]  block_buf [64];
    logic [60:0] bytes_seen;

    // Digest words still owed by the engine, oldest first.
    digest_word_t digest_q [$];
    digest_word_t expected_word;

    stim_row_t directed_rows [N_DIRECTED];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int items_sent     = 0;
    int bytes_absorbed = 0;
    int messages_done  = 0;
    int words_checked  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #5_000_000;
        $display("%0t: timeout, engine stopped making progress", $time);
        $display("sha1_hash_engine_tb: FAIL");
        $finish;
    end

    function automatic void reset_chain();
        for (int i = 0; i < 5; i++)
        begin
            chain_h[i] = sha1_pkg::H_INIT[i];
        end
        bytes_seen = '0;
    endfunction

    // Run the 80 rounds over the current block and fold the result into the chain.
    function automatic void compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, mix, sum;
        for (int r = 0; r < 16; r++)
        begin
            w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
        end
        for (int r = 16; r < 80; r++)
        begin
            mix  = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
            w[r] = {mix[30:0], mix[31]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K_0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_3;
            end
            sum = {a[26:0], a[31:27]} + f + e + k + w[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        chain_h[0] = chain_h[0] + a;
        chain_h[1] = chain_h[1] + b;
        chain_h[2] = chain_h[2] + c;
        chain_h[3] = chain_h[3] + d;
        chain_h[4] = chain_h[4] + e;
    endfunction

    // Advance the software hash by one transaction; return 1 with the digest on finish.
    function automatic logic hash_step(input sha1_pkg::cmd_t kind, input logic [7:0] octet,
                                       output logic [159:0] digest);
        logic [63:0] bit_len;
        int          pos;
        digest = '0;
        pos    = int'(bytes_seen[5:0]);
        if (kind == sha1_pkg::CMD_BYTE)
        begin
            block_buf[pos] = octet;
            bytes_seen     = bytes_seen + 61'd1;
            if (pos == 63)
            begin
                compress_block();
            end
            return 1'b0;
        end
        bit_len        = {bytes_seen, 3'b000};
        block_buf[pos] = sha1_pkg::PAD_BYTE;
        pos++;
        // No room for the length: pad this block out and spill into a fresh one.
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                block_buf[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56)
        begin
            block_buf[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
        begin
            block_buf[56+i] = bit_len[63-8*i -: 8];
        end
        compress_block();
        digest = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
        reset_chain();
        return 1'b1;
    endfunction

    function automatic void queue_digest(input logic [159:0] digest);
        for (int i = 0; i < 5; i++)
        begin
            digest_q.push_back('{word_val: digest[159-32*i -: 32],
                                 word_idx: 3'(i),
                                 is_last:  (i == 4)});
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endfunction

    // Present one transaction, hold it until the engine takes it, then predict.
    task automatic send_item(input sha1_pkg::cmd_t kind, input logic [7:0] octet,
                             input logic known, input logic [159:0] known_digest);
        logic [159:0] predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        action    <= kind;
        data_byte <= octet;
        do
            @(posedge clk);
        while (!req_ready);
        items_sent++;
        if (kind == sha1_pkg::CMD_BYTE)
        begin
            bytes_absorbed++;
        end
        if (hash_step(kind, octet, predicted))
        begin
            messages_done++;
            if (known)
            begin
                // Cross-check the software hash against the textbook digest too.
                if (predicted !== known_digest)
                begin
                    error_count++;
                    $display("%0t: software digest mismatch, expected %h actual %h",
                             $time, known_digest, predicted);
                end
                queue_digest(known_digest);
            end
            else
            begin
                queue_digest(predicted);
            end
        end
    endtask

    // Drop valid and hold off until every owed digest word has come back.
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (digest_q.size() != 0);
    endtask

    // Feed a random message of the given length, then a finish with random junk data.
    task automatic hash_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_item(sha1_pkg::CMD_BYTE, 8'($urandom_range(255)), 1'b0, '0);
        end
        send_item(sha1_pkg::CMD_FINISH, 8'($urandom_range(255)), 1'b0, '0);
    endtask

    // Pick a length: mostly short messages, often right at the padding edges
    // (55 fits the length field, 56 spills into a second block, 63/64 straddle
    // a full block), now and then a longer message of 100 to 130 bytes.
    function automatic int pick_length();
        int sel;
        sel = $urandom_range(7);
        if (sel < 4)
        begin
            return $urandom_range(12);
        end
        else if (sel < 7)
        begin
            case ($urandom_range(3))
                0: return 55;
                1: return 56;
                2: return 63;
                default: return 64;
            endcase
        end
        return $urandom_range(130, 100);
    endfunction

    // Receiver: stall at random at the rate of the current phase.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Checker: compare each returned digest word with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            words_checked++;
            if (digest_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected digest word, expected none actual %h idx %0d last %b",
                         $time, digest_word, word_index, last);
            end
            else
            begin
                expected_word = digest_q.pop_front();
                check_field("digest_word", expected_word.word_val, digest_word);
                check_field("word_index", 32'(expected_word.word_idx), 32'(word_index));
                check_field("last", 32'(expected_word.is_last), 32'(last));
            end
        end
    end

    initial
    begin
        // Directed table: empty message right after reset and again with junk data
        // on the finish, the textbook "abc", byte extremes, and an empty message
        // after a digest to confirm the engine returns to its initial values.
        directed_rows[0]  = '{sha1_pkg::CMD_FINISH, 8'h00, 1'b1, EMPTY_DIGEST};
        directed_rows[1]  = '{sha1_pkg::CMD_FINISH, 8'hFF, 1'b1, EMPTY_DIGEST};
        directed_rows[2]  = '{sha1_pkg::CMD_BYTE,   8'h61, 1'b0, 160'h0};
        directed_rows[3]  = '{sha1_pkg::CMD_BYTE,   8'h62, 1'b0, 160'h0};
        directed_rows[4]  = '{sha1_pkg::CMD_BYTE,   8'h63, 1'b0, 160'h0};
        directed_rows[5]  = '{sha1_pkg::CMD_FINISH, 8'hA5, 1'b1, ABC_DIGEST};
        directed_rows[6]  = '{sha1_pkg::CMD_BYTE,   8'h00, 1'b0, 160'h0};
        directed_rows[7]  = '{sha1_pkg::CMD_BYTE,   8'hFF, 1'b0, 160'h0};
        directed_rows[8]  = '{sha1_pkg::CMD_FINISH, 8'h00, 1'b0, 160'h0};
        directed_rows[9]  = '{sha1_pkg::CMD_BYTE,   8'hFF, 1'b0, 160'h0};
        directed_rows[10] = '{sha1_pkg::CMD_FINISH, 8'hFF, 1'b0, 160'h0};
        directed_rows[11] = '{sha1_pkg::CMD_BYTE,   8'h00, 1'b0, 160'h0};
        directed_rows[12] = '{sha1_pkg::CMD_FINISH, 8'h00, 1'b0, 160'h0};
        directed_rows[13] = '{sha1_pkg::CMD_FINISH, 8'h3C, 1'b1, EMPTY_DIGEST};

        reset_chain();
        for (int i = 0; i < 64; i++)
        begin
            block_buf[i] = 8'h00;
        end

        // Hold reset at the start, then release it once.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_item(directed_rows[i].kind, directed_rows[i].octet,
                      directed_rows[i].known, directed_rows[i].digest);
        end
        // Pause the sender until every digest word is back.
        drain();

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 51;
                end
                default:
                begin
                    send_idle_pct  = 23;
                    recv_stall_pct = 23;
                end
            endcase
            begin
                int phase_start;
                int room;
                int msg_len;
                phase_start = items_sent;
                while (items_sent - phase_start < PHASE_ITEMS)
                begin
                    // Trim the closing message so the phase ends on its budget.
                    room    = PHASE_ITEMS - (items_sent - phase_start);
                    msg_len = pick_length();
                    if (msg_len > room - 1)
                    begin
                        msg_len = room - 1;
                    end
                    hash_message(msg_len);
                end
            end
            drain();
        end

        // Let any trailing activity settle before the verdict.
        recv_stall_pct = 0;
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("Covered %0d transactions: %0d bytes over %0d messages, %0d digest words.",
                 items_sent, bytes_absorbed, messages_done, words_checked);
        $display("Included empty messages, padding spill blocks and idle/stall mixes.");
        if (error_count == 0 && digest_q.size() == 0)
        begin
            $display("sha1_hash_engine_tb: PASS");
        end
        else
        begin
            $display("%0d errors, %0d digest words outstanding", error_count, digest_q.size());
            $display("sha1_hash_engine_tb: FAIL");
        end
        $finish;
    end

endmodule
